FILE: rtl/ebml_vint_decoder_assert.svh
// assertion macros used by the checker file of the vint decoder
`ifndef EBML_VINT_DECODER_ASSERT_SVH
`define EBML_VINT_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define EVD_ASSERT_NOW(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error("ebml vint decoder check failed");

// next-cycle implication, disabled while reset is asserted
`define EVD_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error("ebml vint decoder check failed");

`endif

FILE: rtl/ebmlv_pkg.sv
// shared types and constants of the ebml vint decoder
`timescale 1ns / 1ps

package ebmlv_pkg;

	// mode codes carried on the first byte of a value
	localparam logic [2:0] MODE_ID    = 3'd0;
	localparam logic [2:0] MODE_UVINT = 3'd1;
	localparam logic [2:0] MODE_SVINT = 3'd2;
	localparam logic [2:0] MODE_FIXU  = 3'd3;
	localparam logic [2:0] MODE_FIXS  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_MARKER = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;

	// longest value in bytes
	localparam logic [3:0] MAX_LEN = 4'd8;

	// signed vint bias for the 1-, 2- and 3-byte forms
	localparam logic [63:0] SV_BIAS1 = 64'd63;
	localparam logic [63:0] SV_BIAS2 = 64'd8191;
	localparam logic [63:0] SV_BIAS3 = 64'd1048575;

	typedef struct packed {
		logic [63:0] acc;
		logic [2:0]  bytes_left;
		logic [2:0]  mode;
		logic [3:0]  total_len;
		logic        in_value;
	} dec_state_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] value;
		logic [3:0]  length;
		logic [1:0]  status;
	} dec_result_t;

endpackage

FILE: rtl/ebmlv_step.sv
// next-state and result logic for one stream byte
`timescale 1ns / 1ps

module ebmlv_step (
	input  ebmlv_pkg::dec_state_t  cur,
	input  logic [2:0]             action,
	input  logic [7:0]             data_byte,
	input  logic [3:0]             fixed_length,
	output ebmlv_pkg::dec_state_t  nxt,
	output ebmlv_pkg::dec_result_t res
);

	logic [3:0] vlen;
	logic [7:0] keep;
	logic [3:0] flen;

	// vint length from the highest set bit, plus the mask below the marker
	always_comb begin
		vlen = 4'd0;
		keep = 8'd0;
		for (int i = 0; i < 8; i++) begin
			if (data_byte[i]) begin
				vlen = 4'(8 - i);
				keep = 8'((9'd1 << i) - 9'd1);
			end
		end
	end

	// clamp fixed length into 1..8
	always_comb begin
		if (fixed_length == 4'd0) begin
			flen = 4'd1;
		end else if (fixed_length > ebmlv_pkg::MAX_LEN) begin
			flen = ebmlv_pkg::MAX_LEN;
		end else begin
			flen = fixed_length;
		end
	end

	always_comb begin
		logic start;
		logic fin;
		nxt   = cur;
		res   = '0;
		start = 1'b0;
		fin   = 1'b0;

		if (cur.in_value) begin
			nxt.acc        = {cur.acc[55:0], data_byte};
			nxt.bytes_left = cur.bytes_left - 3'd1;
			fin            = (nxt.bytes_left == 3'd0);
		end else if (action == ebmlv_pkg::MODE_ID || action == ebmlv_pkg::MODE_UVINT ||
		             action == ebmlv_pkg::MODE_SVINT) begin
			if (data_byte == 8'd0) begin
				res.valid  = 1'b1;
				res.value  = 64'd0;
				res.length = 4'd1;
				res.status = ebmlv_pkg::ST_NO_MARKER;
			end else begin
				nxt.mode      = action;
				nxt.total_len = vlen;
				nxt.acc       = (action == ebmlv_pkg::MODE_ID) ? {56'd0, data_byte}
				                                               : {56'd0, data_byte & keep};
				start         = 1'b1;
			end
		end else if (action == ebmlv_pkg::MODE_FIXU || action == ebmlv_pkg::MODE_FIXS) begin
			nxt.mode      = action;
			nxt.total_len = flen;
			nxt.acc       = {{56{(action == ebmlv_pkg::MODE_FIXS) & data_byte[7]}}, data_byte};
			start         = 1'b1;
		end

		if (start) begin
			if (nxt.total_len == 4'd1) begin
				fin = 1'b1;
			end else begin
				nxt.bytes_left = 3'(nxt.total_len - 4'd1);
				nxt.in_value   = 1'b1;
			end
		end

		if (fin) begin
			nxt.in_value   = 1'b0;
			nxt.bytes_left = 3'd0;
			res.valid      = 1'b1;
			res.length     = nxt.total_len;
			res.status     = ebmlv_pkg::ST_OK;
			res.value      = nxt.acc;
			if (nxt.mode == ebmlv_pkg::MODE_SVINT) begin
				unique case (nxt.total_len)
					4'd1: res.value = nxt.acc - ebmlv_pkg::SV_BIAS1;
					4'd2: res.value = nxt.acc - ebmlv_pkg::SV_BIAS2;
					4'd3: res.value = nxt.acc - ebmlv_pkg::SV_BIAS3;
					default: begin
						res.value  = 64'd0;
						res.status = ebmlv_pkg::ST_TOO_LONG;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/ebml_vint_decoder.sv
// top level of the ebml vint decoder: byte stream in, decoded values out
// a result leaves in the cycle after the request that carries the last byte of a value
// throughput: one byte per cycle unless a result stalls; the output register frees in the
// cycle its result is taken; step logic between state and output registers sets that rate
// reset (arst_n low, asynchronous): decoder idle, accumulator and counters zero, no result held
`timescale 1ns / 1ps

module ebml_vint_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte [7:0], fixed_length [11:8], zero [15:12]
	input  logic [2:0]  s_axis_tuser,  // action [2:0]
	// decoded values
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // value [63:0], value_length [67:64], zero [71:68]
	output logic [1:0]  m_axis_tuser   // status [1:0]
);

	ebmlv_pkg::dec_state_t  state_q;
	ebmlv_pkg::dec_state_t  state_n;
	ebmlv_pkg::dec_result_t res;

	logic        out_valid_q;
	logic [63:0] value_q;
	logic [3:0]  length_q;
	logic [1:0]  status_q;
	logic        in_acc;

	// a new byte enters whenever the output register is empty or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// one byte folded into the decoder state in a single pass
	ebmlv_step u_step (
		.cur          (state_q),
		.action       (s_axis_tuser),
		.data_byte    (s_axis_tdata[7:0]),
		.fixed_length (s_axis_tdata[11:8]),
		.nxt          (state_n),
		.res          (res)
	);

	// decoder state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q     <= state_n;
				out_valid_q <= res.valid;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only when a byte completes a value
	always_ff @(posedge clk) begin
		if (in_acc && res.valid) begin
			value_q  <= res.value;
			length_q <= res.length;
			status_q <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, length_q, value_q};
	assign m_axis_tuser  = status_q;

endmodule

FILE: rtl/ebmlv_checker.sv
// port-level checks of the ebml vint decoder and their binding
`timescale 1ns / 1ps
`include "ebml_vint_decoder_assert.svh"

module ebmlv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result holds
	`EVD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// an empty output register always takes a request
	`EVD_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	// value length stays within one to eight bytes
	`EVD_ASSERT_NOW(a_len_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[67:64] != 4'd0 && m_axis_tdata[67:64] <= ebmlv_pkg::MAX_LEN)
	// a missing marker is a single zero byte
	`EVD_ASSERT_NOW(a_no_marker, clk, arst_n, m_axis_tvalid && m_axis_tuser == ebmlv_pkg::ST_NO_MARKER, m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[67:64] == 4'd1)
	// an over-long signed vint reports zero and at least four bytes
	`EVD_ASSERT_NOW(a_too_long, clk, arst_n, m_axis_tvalid && m_axis_tuser == ebmlv_pkg::ST_TOO_LONG, m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[67:64] >= 4'd4)

endmodule

bind ebml_vint_decoder ebmlv_checker u_ebmlv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
